### src/uqesc_pkg.sv
// ----------------------------------------------------------------------------
// uqesc_pkg: shared types, constants and functions for the quote escaper
// Character codes, plan slot numbering and the escape byte generators.
// ----------------------------------------------------------------------------
package uqesc_pkg;

  // ASCII codes used by the escapes
  localparam logic [6:0] CH_BSL   = 7'h5C;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_U_LO  = 7'h75;
  localparam logic [6:0] CH_U_HI  = 7'h55;
  localparam logic [6:0] CH_A     = 7'h61;
  localparam logic [6:0] CH_B     = 7'h62;
  localparam logic [6:0] CH_T     = 7'h74;
  localparam logic [6:0] CH_N     = 7'h6E;
  localparam logic [6:0] CH_V     = 7'h76;
  localparam logic [6:0] CH_F     = 7'h66;
  localparam logic [6:0] CH_R     = 7'h72;
  localparam logic [6:0] CH_DEL   = 7'h7F;
  localparam logic [6:0] QUOTE_RST = 7'd34;

  // Plan slots, emitted lowest first
  localparam int NUM_SLOTS = 9;
  localparam logic [3:0] SLOT_OPEN  = 4'd0;
  localparam logic [3:0] SLOT_PRE0  = 4'd1;
  localparam logic [3:0] SLOT_PRE1  = 4'd2;
  localparam logic [3:0] SLOT_PRE2  = 4'd3;
  localparam logic [3:0] SLOT_MAIN  = 4'd4;
  localparam logic [3:0] SLOT_POST0 = 4'd5;
  localparam logic [3:0] SLOT_POST1 = 4'd6;
  localparam logic [3:0] SLOT_POST2 = 4'd7;
  localparam logic [3:0] SLOT_CLOSE = 4'd8;

  // Escape plan for one input byte
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [2:0][7:0]      pre;
    logic [2:0][7:0]      post;
    logic                 main_hex;
    logic [20:0]          main;
  } plan_t;

  function automatic logic [6:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return 7'h30 + {3'b000, n};
    else return 7'h57 + {3'b000, n};
  endfunction

  // \xNN, byte k of 4
  function automatic logic [6:0] hex_char(input logic [7:0] v, input logic [3:0] k);
    logic [6:0] c;
    case (k)
      4'd0: c = CH_BSL;
      4'd1: c = CH_X;
      4'd2: c = hex_digit(v[7:4]);
      default: c = hex_digit(v[3:0]);
    endcase
    return c;
  endfunction

  function automatic logic is_ctl_letter(input logic [20:0] r);
    return (r >= 21'd7) && (r <= 21'd13);
  endfunction

  function automatic logic is_quoted(input logic [20:0] r, input logic [6:0] q);
    return (r[20:7] == '0) && ((r[6:0] == q) || (r[6:0] == CH_BSL));
  endfunction

  // Number of output bytes for one rune
  function automatic logic [3:0] rune_len(input logic [20:0] r, input logic [6:0] q);
    logic [3:0] n;
    if (is_quoted(r, q)) n = 4'd2;
    else if ((r >= 21'h20) && (r <= 21'h7E)) n = 4'd1;
    else if (is_ctl_letter(r)) n = 4'd2;
    else if ((r < 21'h20) || (r == 21'h7F)) n = 4'd4;
    else if (r < 21'h10000) n = 4'd6;
    else n = 4'd10;
    return n;
  endfunction

  // Byte k of the escaped rune
  function automatic logic [6:0] rune_char(input logic [20:0] r, input logic [6:0] q,
                                           input logic [3:0] k);
    logic [31:0] w;
    logic [3:0]  nib;
    logic [6:0]  c;
    w   = {11'b0, r};
    nib = 4'd0;
    c   = CH_BSL;
    if (is_quoted(r, q)) begin
      c = (k == 4'd0) ? CH_BSL : r[6:0];
    end else if ((r >= 21'h20) && (r <= 21'h7E)) begin
      c = r[6:0];
    end else if (is_ctl_letter(r)) begin
      if (k != 4'd0) begin
        case (r[3:0])
          4'd7:    c = CH_A;
          4'd8:    c = CH_B;
          4'd9:    c = CH_T;
          4'd10:   c = CH_N;
          4'd11:   c = CH_V;
          4'd12:   c = CH_F;
          default: c = CH_R;
        endcase
      end
    end else if ((r < 21'h20) || (r == 21'h7F)) begin
      c = hex_char(r[7:0], k);
    end else if (r < 21'h10000) begin
      case (k)
        4'd2:    nib = w[15:12];
        4'd3:    nib = w[11:8];
        4'd4:    nib = w[7:4];
        default: nib = w[3:0];
      endcase
      if (k == 4'd0) c = CH_BSL;
      else if (k == 4'd1) c = CH_U_LO;
      else c = hex_digit(nib);
    end else begin
      case (k)
        4'd2:    nib = w[31:28];
        4'd3:    nib = w[27:24];
        4'd4:    nib = w[23:20];
        4'd5:    nib = w[19:16];
        4'd6:    nib = w[15:12];
        4'd7:    nib = w[11:8];
        4'd8:    nib = w[7:4];
        default: nib = w[3:0];
      endcase
      if (k == 4'd0) c = CH_BSL;
      else if (k == 4'd1) c = CH_U_HI;
      else c = hex_digit(nib);
    end
    return c;
  endfunction

endpackage

### src/utf8_ascii_quote_escaper.sv
// ----------------------------------------------------------------------------
// utf8_ascii_quote_escaper: UTF-8 to ASCII quoted-literal escaper
// Decodes a UTF-8 byte stream and writes it back as a quoted, escaped literal.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle, while the output is not stalled, as long
// as each byte yields at most one output byte; a byte that expands into N
// output bytes holds the escape serializer (the plan register) until its last
// byte is passed on, and input ready stays low until then. Bytes that only
// extend a UTF-8 sequence produce no output. The first output byte of an accepted
// input passes the plan register, then the output register. The user must write the quote
// character through the cfg channel only between strings; the block itself does not enforce this. It is always ready.
module utf8_ascii_quote_escaper (
  input  logic       clk,
  input  logic       rst,
  // input bytes
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  // escaped output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_byte,
  output logic       last_of_run,
  // quote character register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  import uqesc_pkg::*;

  // Decoder state
  logic [6:0]      quote_char;
  logic [2:0][7:0] pending_bytes, pending_bytes_next;
  logic [1:0]      pending_count, pending_count_next;
  logic [2:0]      sequence_length, sequence_length_next;
  logic            inside_string, inside_string_next;

  // Serializer state
  plan_t      plan, plan_new;
  logic [3:0] kidx;

  logic       in_fire, out_free, plan_busy, plan_adv, final_byte, unit_last;
  logic [3:0] cur, cur_len;
  logic [6:0] cur_byte;
  logic [7:0] hex_val;
  logic       cur_is_hex, cur_is_quote;
  logic [7:0] lo, hi;
  logic       do_start;
  logic [20:0] rune;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign plan_busy = |plan.mask;
  assign plan_adv  = plan_busy && out_free;
  assign in_ready  = !plan_busy || (out_free && final_byte);

  // Build the escape plan for the incoming byte and the next decoder state
  always_comb begin
    plan_new             = '0;
    plan_new.pre         = pending_bytes;
    pending_bytes_next   = pending_bytes;
    pending_count_next   = pending_count;
    sequence_length_next = sequence_length;
    inside_string_next   = inside_string;
    lo       = 8'h80;
    hi       = 8'hBF;
    do_start = 1'b0;
    rune     = '0;

    if (!inside_string) plan_new.mask[SLOT_OPEN] = 1'b1;

    case (sequence_length)
      3'd2:    rune = {10'b0, pending_bytes[0][4:0], data_byte[5:0]};
      3'd3:    rune = {5'b0, pending_bytes[0][3:0], pending_bytes[1][5:0], data_byte[5:0]};
      default: rune = {pending_bytes[0][2:0], pending_bytes[1][5:0],
                       pending_bytes[2][5:0], data_byte[5:0]};
    endcase

    if (pending_count == 2'd0) begin
      do_start = 1'b1;
    end else begin
      // second byte range depends on the lead
      if (pending_count == 2'd1) begin
        case (pending_bytes[0])
          8'hE0:   lo = 8'hA0;
          8'hED:   hi = 8'h9F;
          8'hF0:   lo = 8'h90;
          8'hF4:   hi = 8'h8F;
          default: ;
        endcase
      end
      if ((data_byte < lo) || (data_byte > hi)) begin
        // broken sequence: flush buffered bytes as \xNN
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < pending_count) plan_new.mask[SLOT_PRE0 + 4'(i)] = 1'b1;
        end
        pending_count_next   = 2'd0;
        sequence_length_next = 3'd0;
        do_start             = 1'b1;
      end else if (({1'b0, pending_count} + 3'd1) < sequence_length) begin
        pending_bytes_next[pending_count] = data_byte;
        pending_count_next = pending_count + 2'd1;
      end else begin
        plan_new.main            = rune;
        plan_new.mask[SLOT_MAIN] = 1'b1;
        pending_count_next       = 2'd0;
        sequence_length_next     = 3'd0;
      end
    end

    // byte opens a new rune
    if (do_start) begin
      if (!data_byte[7]) begin
        plan_new.main            = {13'b0, data_byte};
        plan_new.mask[SLOT_MAIN] = 1'b1;
      end else if ((data_byte >= 8'hC2) && (data_byte <= 8'hDF)) begin
        sequence_length_next  = 3'd2;
        pending_bytes_next[0] = data_byte;
        pending_count_next    = 2'd1;
      end else if ((data_byte >= 8'hE0) && (data_byte <= 8'hEF)) begin
        sequence_length_next  = 3'd3;
        pending_bytes_next[0] = data_byte;
        pending_count_next    = 2'd1;
      end else if ((data_byte >= 8'hF0) && (data_byte <= 8'hF4)) begin
        sequence_length_next  = 3'd4;
        pending_bytes_next[0] = data_byte;
        pending_count_next    = 2'd1;
      end else begin
        plan_new.main            = {13'b0, data_byte};
        plan_new.main_hex        = 1'b1;
        plan_new.mask[SLOT_MAIN] = 1'b1;
      end
    end

    // end of string: flush truncated sequence, close the literal
    plan_new.post = pending_bytes_next;
    if (end_of_string) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pending_count_next) plan_new.mask[SLOT_POST0 + 4'(i)] = 1'b1;
      end
      pending_count_next        = 2'd0;
      sequence_length_next      = 3'd0;
      plan_new.mask[SLOT_CLOSE] = 1'b1;
      inside_string_next        = 1'b0;
    end else begin
      inside_string_next = 1'b1;
    end
  end

  // Current slot: lowest pending one
  always_comb begin
    cur = SLOT_CLOSE;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (plan.mask[i]) cur = 4'(i);
    end
  end

  // Byte generation for the current slot
  always_comb begin
    hex_val      = plan.main[7:0];
    cur_is_hex   = 1'b0;
    cur_is_quote = 1'b0;
    case (cur)
      SLOT_OPEN, SLOT_CLOSE: cur_is_quote = 1'b1;
      SLOT_PRE0:  begin cur_is_hex = 1'b1; hex_val = plan.pre[0];  end
      SLOT_PRE1:  begin cur_is_hex = 1'b1; hex_val = plan.pre[1];  end
      SLOT_PRE2:  begin cur_is_hex = 1'b1; hex_val = plan.pre[2];  end
      SLOT_POST0: begin cur_is_hex = 1'b1; hex_val = plan.post[0]; end
      SLOT_POST1: begin cur_is_hex = 1'b1; hex_val = plan.post[1]; end
      SLOT_POST2: begin cur_is_hex = 1'b1; hex_val = plan.post[2]; end
      default:    cur_is_hex = plan.main_hex;
    endcase
    if (cur_is_quote) begin
      cur_byte = quote_char;
      cur_len  = 4'd1;
    end else if (cur_is_hex) begin
      cur_byte = hex_char(hex_val, kidx);
      cur_len  = 4'd4;
    end else begin
      cur_byte = rune_char(plan.main, quote_char, kidx);
      cur_len  = rune_len(plan.main, quote_char);
    end
    unit_last  = (kidx == (cur_len - 4'd1));
    final_byte = unit_last && ((plan.mask & (plan.mask - 9'd1)) == '0);
  end

  // Decoder state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char      <= QUOTE_RST;
      pending_count   <= 2'd0;
      sequence_length <= 3'd0;
      inside_string   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) quote_char <= cfg_data;
      if (in_fire) begin
        pending_count   <= pending_count_next;
        sequence_length <= sequence_length_next;
        inside_string   <= inside_string_next;
      end
    end
  end

  // Buffered sequence bytes
  always_ff @(posedge clk) begin
    if (in_fire) pending_bytes <= pending_bytes_next;
  end

  // Plan register and serializer position
  always_ff @(posedge clk) begin
    if (rst) begin
      plan.mask <= '0;
      kidx      <= 4'd0;
    end else if (in_fire) begin
      plan <= plan_new;
      kidx <= 4'd0;
    end else if (plan_adv) begin
      if (unit_last) begin
        plan.mask[cur] <= 1'b0;
        kidx           <= 4'd0;
      end else begin
        kidx <= kidx + 4'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= plan_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (plan_adv) begin
      out_byte    <= cur_byte;
      last_of_run <= final_byte;
    end
  end

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (plan_busy && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while serializer is stalled");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 2'd0) |-> ({1'b0, pending_count} < sequence_length))
    else $error("pending count not below sequence length");

  a_empty_no_len: assert property (@(posedge clk) disable iff (rst)
    (pending_count == 2'd0) |-> (sequence_length == 3'd0))
    else $error("sequence length left without buffered bytes");

  a_kidx_in_unit: assert property (@(posedge clk) disable iff (rst)
    plan_busy |-> (kidx < cur_len))
    else $error("serializer index past end of unit");

  a_eos_closes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_of_string) |=> (!inside_string && (pending_count == 2'd0)))
    else $error("string still open after end mark");

endmodule

### bench/escape_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_checker: scoreboard for the UTF-8 quote escaper
// Watches the input, output and quote register channels. Every accepted
// input byte is run through a local copy of the escaper state; the bytes of
// the literal that it should produce are queued and compared in order with
// the bytes that leave the block.
// ----------------------------------------------------------------------------
module escape_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] out_byte,
  input  logic       last_of_run,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         awaiting,
  output int         bytes_checked
);

  // ASCII characters of the escapes
  localparam logic [6:0] BSLASH = 7'h5C;
  localparam logic [6:0] LC_X   = 7'h78;
  localparam logic [6:0] LC_U   = 7'h75;
  localparam logic [6:0] UC_U   = 7'h55;
  localparam logic [6:0] LC_A   = 7'h61;
  localparam logic [6:0] LC_B   = 7'h62;
  localparam logic [6:0] LC_T   = 7'h74;
  localparam logic [6:0] LC_N   = 7'h6E;
  localparam logic [6:0] LC_V   = 7'h76;
  localparam logic [6:0] LC_F   = 7'h66;
  localparam logic [6:0] LC_R   = 7'h72;
  localparam logic [6:0] DEL    = 7'h7F;

  // controls with a letter escape
  localparam logic [20:0] BEL = 21'd7;
  localparam logic [20:0] BS  = 21'd8;
  localparam logic [20:0] HT  = 21'd9;
  localparam logic [20:0] LF  = 21'd10;
  localparam logic [20:0] VT  = 21'd11;
  localparam logic [20:0] FF  = 21'd12;
  localparam logic [20:0] CR  = 21'd13;

  typedef struct packed {
    logic [6:0] ch;
    logic       tail;
  } lit_byte_t;

  // escaper state as seen from outside
  logic [6:0]  quote_q;
  logic [7:0]  seq_buf [3];
  int unsigned seq_cnt;
  int unsigned seq_len;
  logic        str_open;

  logic [6:0]  run_chars [$];
  lit_byte_t   literal_q [$];
  int          n_fail;
  int          n_checked;

  initial begin
    quote_q   = uqesc_pkg::QUOTE_RST;
    seq_cnt   = 0;
    seq_len   = 0;
    str_open  = 1'b0;
    n_fail    = 0;
    n_checked = 0;
    fail_count    = 0;
    awaiting      = 0;
    bytes_checked = 0;
  end

  function automatic logic [6:0] hex_nib(input logic [3:0] n);
    return (n > 4'd9) ? 7'h57 + {3'b000, n} : 7'h30 + {3'b000, n};
  endfunction

  task automatic put_char(input logic [6:0] c);
    run_chars.push_back(c);
  endtask

  task automatic put_hex_byte(input logic [7:0] b);
    put_char(BSLASH);
    put_char(LC_X);
    put_char(hex_nib(b[7:4]));
    put_char(hex_nib(b[3:0]));
  endtask

  // one decoded code point, escaped for an ASCII-only literal
  task automatic put_rune(input logic [20:0] r);
    logic [31:0] w;
    w = {11'd0, r};
    if (r == {14'd0, quote_q} || r == {14'd0, BSLASH}) begin
      put_char(BSLASH);
      put_char(r[6:0]);
    end else if (r >= 21'h20 && r <= 21'h7E) begin
      put_char(r[6:0]);
    end else if (r >= BEL && r <= CR) begin
      put_char(BSLASH);
      case (r)
        BEL:     put_char(LC_A);
        BS:      put_char(LC_B);
        HT:      put_char(LC_T);
        LF:      put_char(LC_N);
        VT:      put_char(LC_V);
        FF:      put_char(LC_F);
        default: put_char(LC_R);
      endcase
    end else if (r < 21'h20 || r == {14'd0, DEL}) begin
      put_hex_byte(r[7:0]);
    end else if (r < 21'h10000) begin
      put_char(BSLASH);
      put_char(LC_U);
      for (int i = 3; i >= 0; i--) put_char(hex_nib(w[i*4 +: 4]));
    end else begin
      put_char(BSLASH);
      put_char(UC_U);
      for (int i = 7; i >= 0; i--) put_char(hex_nib(w[i*4 +: 4]));
    end
  endtask

  // buffered bytes of an unfinished sequence go out as \xNN
  task automatic flush_seq();
    for (int i = 0; i < seq_cnt; i++) put_hex_byte(seq_buf[i]);
    seq_cnt = 0;
    seq_len = 0;
  endtask

  task automatic start_seq(input logic [7:0] b);
    if (b < 8'h80) begin
      put_rune({13'd0, b});
      return;
    end
    if (b >= 8'hC2 && b <= 8'hDF) seq_len = 2;
    else if (b >= 8'hE0 && b <= 8'hEF) seq_len = 3;
    else if (b >= 8'hF0 && b <= 8'hF4) seq_len = 4;
    else begin
      // stray continuation or a lead byte that can never be valid
      put_hex_byte(b);
      return;
    end
    seq_buf[0] = b;
    seq_cnt    = 1;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] r;
    lo = 8'h80;
    hi = 8'hBF;
    if (seq_cnt == 0) begin
      start_seq(b);
      return;
    end
    // second byte range narrows after some leads
    if (seq_cnt == 1) begin
      case (seq_buf[0])
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
    if (b < lo || b > hi) begin
      flush_seq();
      start_seq(b);
      return;
    end
    if (seq_cnt + 1 < seq_len) begin
      seq_buf[seq_cnt] = b;
      seq_cnt++;
      return;
    end
    case (seq_len)
      2:       r = {10'd0, seq_buf[0][4:0], b[5:0]};
      3:       r = {5'd0, seq_buf[0][3:0], seq_buf[1][5:0], b[5:0]};
      default: r = {seq_buf[0][2:0], seq_buf[1][5:0], seq_buf[2][5:0], b[5:0]};
    endcase
    seq_cnt = 0;
    seq_len = 0;
    put_rune(r);
  endtask

  // literal bytes caused by one input request
  task automatic predict_literal(input logic [7:0] b, input logic eos);
    run_chars.delete();
    if (!str_open) begin
      put_char(quote_q);
      str_open = 1'b1;
    end
    take_byte(b);
    if (eos) begin
      flush_seq();
      put_char(quote_q);
      str_open = 1'b0;
    end
    foreach (run_chars[i])
      literal_q.push_back('{ch: run_chars[i], tail: (i == run_chars.size() - 1)});
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    lit_byte_t want;
    if (rst) begin
      quote_q  = uqesc_pkg::QUOTE_RST;
      seq_cnt  = 0;
      seq_len  = 0;
      str_open = 1'b0;
      literal_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) quote_q = cfg_data;
      if (in_valid && in_ready) predict_literal(data_byte, end_of_string);
      if (out_valid && out_ready) begin
        if (literal_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %h last %b",
                   $time, out_byte, last_of_run);
          n_fail++;
        end else begin
          want = literal_q.pop_front();
          n_checked++;
          if (out_byte !== want.ch || last_of_run !== want.tail) begin
            $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                     $time, want.ch, want.tail, out_byte, last_of_run);
            n_fail++;
          end
        end
      end
    end
    fail_count    <= n_fail;
    awaiting      <= literal_q.size();
    bytes_checked <= n_checked;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the UTF-8 quote escaper
// Feeds whole strings (directed edge cases, then random UTF-8 with broken
// and truncated sequences) under several quote characters, with bursty
// input and a varying output stall pattern. The checker scores the output.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEMS_TOTAL  = 260;
  localparam int NUM_PHASES   = 6;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_TRICKLE} rx_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_byte;
  logic       last_of_run;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = 7'd0;

  int         fail_count;
  int         awaiting;
  int         bytes_checked;

  int         cycle_cnt = 0;
  int         items_sent = 0;
  int         strings_sent = 0;
  int         burst_left = 0;
  logic [6:0] quote_now = uqesc_pkg::QUOTE_RST;
  logic [7:0] text_q [$];

  rx_mode_e   rx_mode = RX_OPEN;
  int         rx_left = 0;

  utf8_ascii_quote_escaper u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  escape_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .awaiting      (awaiting),
    .bytes_checked (bytes_checked)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt, awaiting);
      $display("tb NOT OK");
      $finish;
    end
  end

  // output stalls: a random mode, redrawn whenever its count runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (rx_left % 4) != 0;
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one input request; bursts of requests are separated by random gaps
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    strings_sent++;
  endtask

  // stop sending and let every expected byte come out
  task automatic settle();
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_quote(input logic [6:0] q);
    cfg_valid <= 1'b1;
    cfg_data  <= q;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    quote_now = q;
  endtask

  task automatic add_utf8(input logic [20:0] r);
    if (r < 21'h80) begin
      text_q.push_back({1'b0, r[6:0]});
    end else if (r < 21'h800) begin
      text_q.push_back({3'b110, r[10:6]});
      text_q.push_back({2'b10, r[5:0]});
    end else if (r < 21'h10000) begin
      text_q.push_back({4'b1110, r[15:12]});
      text_q.push_back({2'b10, r[11:6]});
      text_q.push_back({2'b10, r[5:0]});
    end else begin
      text_q.push_back({5'b11110, r[20:18]});
      text_q.push_back({2'b10, r[17:12]});
      text_q.push_back({2'b10, r[11:6]});
      text_q.push_back({2'b10, r[5:0]});
    end
  endtask

  function automatic logic [20:0] pick_ascii();
    case ($urandom_range(0, 7))
      0:       return {14'd0, quote_now};
      1:       return 21'h5C;
      2:       return 21'($urandom_range(0, 31));
      3:       return 21'h7F;
      default: return 21'($urandom_range(0, 127));
    endcase
  endfunction

  // a non-ASCII code point, leaning toward the leads with narrow ranges
  function automatic logic [20:0] pick_wide();
    logic [20:0] r;
    case ($urandom_range(0, 5))
      0:       r = 21'($urandom_range(21'h80, 21'h7FF));
      1:       r = 21'($urandom_range(21'h800, 21'hFFF));
      2:       r = 21'($urandom_range(21'hD000, 21'hD7FF));
      3:       r = 21'($urandom_range(21'h1000, 21'hFFFF));
      4:       r = 21'($urandom_range(21'h10000, 21'h3FFFF));
      default: r = 21'($urandom_range(21'h40000, 21'h10FFFF));
    endcase
    if (r >= 21'hD800 && r <= 21'hDFFF) r = r ^ 21'h1000;
    return r;
  endfunction

  // mostly well-formed text, with some noise and cut sequences
  task automatic make_string();
    int n_runes;
    int base;
    n_runes = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
    repeat (n_runes) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_utf8(pick_ascii());
        3, 4, 5, 6: add_utf8(pick_wide());
        7: text_q.push_back(8'($urandom_range(0, 255)));
        8: begin
          base = text_q.size();
          add_utf8(pick_wide());
          repeat ($urandom_range(1, text_q.size() - base - 1)) void'(text_q.pop_back());
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       text_q.push_back(8'hE0);
            1:       text_q.push_back(8'hED);
            2:       text_q.push_back(8'hF0);
            default: text_q.push_back(8'hF4);
          endcase
          text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      endcase
    end
  endtask

  function automatic logic [6:0] phase_quote(input int p);
    case (p)
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'h5C;
      3:       return 7'h27;
      4:       return 7'($urandom_range(0, 127));
      default: return uqesc_pkg::QUOTE_RST;
    endcase
  endfunction

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // escapes of every ASCII class under the reset quote
    text_q = '{8'h22, 8'h5C, 8'h20, 8'h7E, 8'h7F, 8'h00, 8'h07, 8'h08, 8'h09,
               8'h0A, 8'h0B, 8'h0C, 8'h0D};
    send_text();
    // smallest two-byte rune and the largest rune
    text_q = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    // stray continuation, invalid lead, broken sequence, cut at the end
    text_q = '{8'h80, 8'hFF, 8'hE0, 8'h41, 8'hF0, 8'h90};
    send_text();

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_quote(phase_quote(p));
      while (items_sent < 25 + (p + 1) * ((ITEMS_TOTAL - 25) / NUM_PHASES)) begin
        make_string();
        send_text();
      end
    end
    settle();

    $display("sent %0d input bytes in %0d strings under %0d quote characters",
             items_sent, strings_sent, NUM_PHASES);
    $display("checked %0d escaped output bytes, %0d failures", bytes_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
